>>> rtl/mhpq_pkg.sv
// shared constants, types and status codes of the max-heap priority queue
// no dependencies
package mhpq_pkg;

    localparam int DEPTH      = 128;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CH_W       = IDX_W + 2;
    localparam int CODE_W     = 16;
    localparam int PRIO_W     = 16;
    localparam int ENT_W      = CODE_W + PRIO_W;
    localparam int MAXE_W     = 8;
    localparam int MAXE_RESET = 128;
    localparam int STAT_W     = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr_a;
        logic [IDX_W-1:0] raddr_b;
    } t_mem_req;

endpackage

>>> rtl/mhpq_ram.sv
// generic synchronous ram, one write port and two registered read ports
// no dependencies
module mhpq_ram #(
    parameter int AW = 7,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

>>> rtl/mhpq_cfg.sv
// apb configuration register: capacity limit
// depends on mhpq_pkg
module mhpq_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mhpq_pkg::APB_AW-1:0]  paddr,
    input  logic [mhpq_pkg::APB_DW-1:0]  pwdata,
    output logic [mhpq_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [mhpq_pkg::MAXE_W-1:0]  o_max_entries
);
    import mhpq_pkg::*;

    logic              sel_max;
    logic [MAXE_W-1:0] r_max_entries;

    assign pready  = 1'b1;
    assign sel_max = (paddr[APB_AW-1] == REG_MAX_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAXE_W'(MAXE_RESET);
        end else if (psel && penable && pwrite && pready && sel_max) begin
            r_max_entries <= pwdata[MAXE_W-1:0];
        end
    end

    assign prdata        = sel_max ? APB_DW'(r_max_entries) : '0;
    assign o_max_entries = r_max_entries;

endmodule

>>> rtl/mhpq_ctrl.sv
// heap sequencer: insert with sift up, extract with sift down, result register
// depends on mhpq_pkg; drives the heap ram through a t_mem_req struct
module mhpq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mhpq_pkg::MAXE_W-1:0]   i_max_entries,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [mhpq_pkg::CODE_W-1:0]   i_code,
    input  logic [mhpq_pkg::PRIO_W-1:0]   i_prio,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mhpq_pkg::t_status             o_status,
    output logic [mhpq_pkg::CODE_W-1:0]   o_code,
    output logic [mhpq_pkg::PRIO_W-1:0]   o_prio,
    output logic [mhpq_pkg::CNT_W-1:0]    o_fill,
    output mhpq_pkg::t_mem_req            o_mem,
    input  mhpq_pkg::t_entry              i_rd_a,
    input  mhpq_pkg::t_entry              i_rd_b
);
    import mhpq_pkg::*;

    localparam int CMP_W = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_RD  = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_EX_RD  = 7'b0001000,
        S_DN_RD  = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_idx, n_idx;
    t_entry            r_ent, n_ent;
    t_status           r_res_status, n_res_status;
    t_entry            r_res, n_res;
    logic              r_ovld, n_ovld;
    t_status           r_o_status, n_o_status;
    t_entry            r_o_ent, n_o_ent;
    logic [CNT_W-1:0]  r_o_fill, n_o_fill;

    logic [CMP_W-1:0]  max_ext, cap, cnt_ext;
    logic              can_insert;
    logic [IDX_W-1:0]  parent;
    logic [CH_W-1:0]   lch, rch, cnt_ch;
    logic              rch_ok, take_r;
    t_entry            child;
    logic [IDX_W-1:0]  child_idx;
    logic              out_free;

    assign max_ext    = CMP_W'(i_max_entries);
    assign cap        = (max_ext < CMP_W'(DEPTH)) ? max_ext : CMP_W'(DEPTH);
    assign cnt_ext    = CMP_W'(r_cnt);
    assign can_insert = cnt_ext < cap;

    assign parent     = (r_idx - IDX_W'(1)) >> 1;
    assign lch        = {1'b0, r_idx, 1'b1};
    assign rch        = lch + CH_W'(1);
    assign cnt_ch     = CH_W'(r_cnt);
    assign rch_ok     = rch < cnt_ch;
    assign take_r     = rch_ok && (i_rd_b.prio > i_rd_a.prio);
    assign child      = take_r ? i_rd_b : i_rd_a;
    assign child_idx  = take_r ? rch[IDX_W-1:0] : lch[IDX_W-1:0];
    assign out_free   = !r_ovld || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_status    = r_o_status;
    assign o_code      = r_o_ent.code;
    assign o_prio      = r_o_ent.prio;
    assign o_fill      = r_o_fill;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_ent        = r_ent;
        n_res_status = r_res_status;
        n_res        = r_res;
        n_ovld       = r_ovld && !i_out_ready;
        n_o_status   = r_o_status;
        n_o_ent      = r_o_ent;
        n_o_fill     = r_o_fill;
        o_mem        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_status = ST_OK;
                    n_res        = '0;
                    n_state      = S_OUT;
                    if (i_op == OP_INSERT) begin
                        if (can_insert) begin
                            n_ent   = '{prio: i_prio, code: i_code};
                            n_idx   = r_cnt[IDX_W-1:0];
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_state = S_UP_RD;
                        end else begin
                            n_res_status = ST_FULL;
                        end
                    end else begin
                        if (r_cnt != '0) begin
                            o_mem.raddr_a = '0;
                            o_mem.raddr_b = IDX_W'(r_cnt - CNT_W'(1));
                            n_cnt         = r_cnt - CNT_W'(1);
                            n_state       = S_EX_RD;
                        end else begin
                            n_res_status = ST_EMPTY;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_idx;
                    o_mem.wdata = r_ent;
                    n_state     = S_OUT;
                end else begin
                    o_mem.raddr_a = parent;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                if (r_ent.prio > i_rd_a.prio) begin
                    o_mem.wdata = i_rd_a;
                    n_idx       = parent;
                    n_state     = S_UP_RD;
                end else begin
                    o_mem.wdata = r_ent;
                    n_state     = S_OUT;
                end
            end
            S_EX_RD: begin
                n_res   = i_rd_a;
                n_ent   = i_rd_b;
                n_idx   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (lch >= cnt_ch) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_idx;
                    o_mem.wdata = r_ent;
                    n_state     = S_OUT;
                end else begin
                    o_mem.raddr_a = lch[IDX_W-1:0];
                    o_mem.raddr_b = rch[IDX_W-1:0];
                    n_state       = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                if (r_ent.prio < child.prio) begin
                    o_mem.wdata = child;
                    n_idx       = child_idx;
                    n_state     = S_DN_RD;
                end else begin
                    o_mem.wdata = r_ent;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovld     = 1'b1;
                    n_o_status = r_res_status;
                    n_o_ent    = r_res;
                    n_o_fill   = r_cnt;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_ent        <= n_ent;
        r_res_status <= n_res_status;
        r_res        <= n_res;
        r_o_status   <= n_o_status;
        r_o_ent      <= n_o_ent;
        r_o_fill     <= n_o_fill;
    end

endmodule

>>> rtl/max_heap_priority_queue.sv
// top level of the max-heap priority queue: stream ports, apb register, heap ram
// depends on mhpq_pkg, mhpq_ram, mhpq_cfg and mhpq_ctrl
//
// channel   | direction | payload
// s_axis    | in        | tuser: op; tdata: code, priority_req
// m_axis    | out       | tdata: status, out_code, out_priority, fill_count
// apb       | in/out    | max_entries at byte address 0
//
// insert: the new entry climbs level by level until it reaches the root or stops below a larger parent
// extract: the last entry moves to the root and descends until it reaches a leaf or stops above its children
// each level is a ram read then compare and write back
// refused inserts and extracts on empty go straight to the result register
// reset clears the fill count and the result valid flag; the ram is not cleared
// the next transfer is taken while a result waits; the sequencer holds only behind it
module max_heap_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // code, priority_req
    input  logic                         s_axis_tuser,  // op
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [47:0]                  m_axis_tdata,  // status, out_code, out_priority,
                                                        // fill_count, zero fill
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mhpq_pkg::APB_AW-1:0]  paddr,
    input  logic [mhpq_pkg::APB_DW-1:0]  pwdata,
    output logic [mhpq_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import mhpq_pkg::*;

    logic [MAXE_W-1:0] max_entries;
    t_mem_req          mem_req;
    t_entry            rd_a, rd_b;
    t_status           status;
    logic [CODE_W-1:0] out_code;
    logic [PRIO_W-1:0] out_prio;
    logic [CNT_W-1:0]  fill;

    mhpq_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_entries (max_entries)
    );

    mhpq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_entries (max_entries),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_code        (s_axis_tdata[CODE_W-1:0]),
        .i_prio        (s_axis_tdata[CODE_W+PRIO_W-1:CODE_W]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (status),
        .o_code        (out_code),
        .o_prio        (out_prio),
        .o_fill        (fill),
        .o_mem         (mem_req),
        .i_rd_a        (rd_a),
        .i_rd_b        (rd_b)
    );

    mhpq_ram #(
        .AW (IDX_W),
        .DW (ENT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_req.we),
        .i_waddr   (mem_req.waddr),
        .i_wdata   (mem_req.wdata),
        .i_raddr_a (mem_req.raddr_a),
        .i_raddr_b (mem_req.raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign m_axis_tdata = 48'({8'(fill), out_prio, out_code, status});

endmodule

>>> tb/tb.sv
// self-checking testbench of max_heap_priority_queue: directed rows, then random
// insert/extract traffic under varied capacity limits and idling; depends on mhpq_pkg
module tb;
    import mhpq_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DIR_N       = 25;
    localparam logic [APB_AW-1:0] ADDR_MAX_ENTRIES = APB_AW'(4 * int'(REG_MAX_ENTRIES));

    typedef struct packed {
        t_status           status;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        logic [7:0]        fill;
    } t_reply;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              op;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        logic [7:0]        cfg;
        logic              typed;
        t_reply            reply;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;  // code, priority_req
    logic              s_axis_tuser = 1'b0;  // op
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;  // status, out_code, out_priority, fill_count, zero fill
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    max_heap_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // mirror of the heap
    t_entry      heap_mirror [DEPTH];
    int unsigned heap_fill;
    logic [7:0]  heap_limit;
    t_reply      replies_due [$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int fail_count    = 0;
    int n_inserts     = 0;
    int n_extracts    = 0;
    int n_refused     = 0;
    int n_empty       = 0;
    int peak_fill     = 0;
    int quiet_cycles  = 0;

    t_dir_row dir_rows [DIR_N] = '{
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b1, '{ST_EMPTY, 16'h0, 16'h0, 8'd0}},
        '{ROW_ITEM, OP_INSERT,  16'hFFFF, 16'hFFFF, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd1}},
        '{ROW_ITEM, OP_INSERT,  16'h0000, 16'h0000, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd2}},
        '{ROW_ITEM, OP_INSERT,  16'h1234, 16'h8000, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd3}},
        '{ROW_ITEM, OP_INSERT,  16'hAAAA, 16'h8000, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd4}},
        '{ROW_ITEM, OP_INSERT,  16'h5555, 16'h8000, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd5}},
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b1,
          '{ST_OK, 16'hFFFF, 16'hFFFF, 8'd4}},
        // equal priorities: order decided by the left-child rule
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b0, '0},
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b0, '0},
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b0, '0},
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd0}},
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b1, '{ST_EMPTY, 16'h0, 16'h0, 8'd0}},
        // zero capacity
        '{ROW_CFG,  OP_INSERT,  16'h0000, 16'h0000, 8'd0,   1'b0, '0},
        '{ROW_ITEM, OP_INSERT,  16'h0101, 16'h0007, 8'd0,   1'b1, '{ST_FULL, 16'h0, 16'h0, 8'd0}},
        '{ROW_CFG,  OP_INSERT,  16'h0000, 16'h0000, 8'd2,   1'b0, '0},
        '{ROW_ITEM, OP_INSERT,  16'h0101, 16'h0007, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd1}},
        '{ROW_ITEM, OP_INSERT,  16'h0202, 16'h0009, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd2}},
        '{ROW_ITEM, OP_INSERT,  16'h0303, 16'hFFFF, 8'd0,   1'b1, '{ST_FULL, 16'h0, 16'h0, 8'd2}},
        // limit lowered below the fill
        '{ROW_CFG,  OP_INSERT,  16'h0000, 16'h0000, 8'd1,   1'b0, '0},
        '{ROW_ITEM, OP_INSERT,  16'h0404, 16'h0001, 8'd0,   1'b1, '{ST_FULL, 16'h0, 16'h0, 8'd2}},
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b1,
          '{ST_OK, 16'h0202, 16'h0009, 8'd1}},
        '{ROW_ITEM, OP_INSERT,  16'h0505, 16'h0002, 8'd0,   1'b1, '{ST_FULL, 16'h0, 16'h0, 8'd1}},
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b1,
          '{ST_OK, 16'h0101, 16'h0007, 8'd0}},
        '{ROW_ITEM, OP_INSERT,  16'hC3C3, 16'h7FFF, 8'd0,   1'b1, '{ST_OK, 16'h0, 16'h0, 8'd1}},
        '{ROW_ITEM, OP_EXTRACT, 16'h0000, 16'h0000, 8'd0,   1'b1,
          '{ST_OK, 16'hC3C3, 16'h7FFF, 8'd0}}
    };

    function automatic t_reply heap_apply_op(input logic op, input logic [CODE_W-1:0] code,
                                             input logic [PRIO_W-1:0] prio);
        t_reply      r;
        t_entry      tmp;
        int unsigned cap;
        int unsigned idx;
        int unsigned par;
        int unsigned best;
        int unsigned lc;
        int unsigned rc;
        bit          moving;
        r = '0;
        r.status = ST_OK;
        cap = (int'(heap_limit) < DEPTH) ? int'(heap_limit) : DEPTH;
        if (op == OP_INSERT) begin
            if (heap_fill < cap) begin
                heap_mirror[heap_fill] = '{prio: prio, code: code};
                idx = heap_fill;
                heap_fill++;
                moving = 1'b1;
                while (moving && idx > 0) begin
                    par = (idx - 1) / 2;
                    if (heap_mirror[idx].prio > heap_mirror[par].prio) begin
                        tmp = heap_mirror[idx];
                        heap_mirror[idx] = heap_mirror[par];
                        heap_mirror[par] = tmp;
                        idx = par;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end else begin
                r.status = ST_FULL;
            end
        end else begin
            if (heap_fill > 0) begin
                r.code = heap_mirror[0].code;
                r.prio = heap_mirror[0].prio;
                heap_fill--;
                heap_mirror[0] = heap_mirror[heap_fill];
                idx = 0;
                moving = 1'b1;
                while (moving) begin
                    lc = 2 * idx + 1;
                    rc = 2 * idx + 2;
                    best = idx;
                    // strict compare keeps the left child on ties
                    if (lc < heap_fill && heap_mirror[best].prio < heap_mirror[lc].prio)
                        best = lc;
                    if (rc < heap_fill && heap_mirror[best].prio < heap_mirror[rc].prio)
                        best = rc;
                    if (best == idx) begin
                        moving = 1'b0;
                    end else begin
                        tmp = heap_mirror[best];
                        heap_mirror[best] = heap_mirror[idx];
                        heap_mirror[idx] = tmp;
                        idx = best;
                    end
                end
            end else begin
                r.status = ST_EMPTY;
            end
        end
        r.fill = 8'(heap_fill);
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic push_item(input logic op, input logic [CODE_W-1:0] code,
                             input logic [PRIO_W-1:0] prio, input logic typed,
                             input t_reply typed_reply);
        t_reply r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {prio, code};
        do @(posedge i_clk); while (!s_axis_tready);
        r = heap_apply_op(op, code, prio);
        replies_due.push_back(typed ? typed_reply : r);
        @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_MAX_ENTRIES;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_limit_readback(input logic [7:0] want);
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[MAXE_W-1:0] !== want) begin
            $error("max_entries: expected %0d, got %0d", want, rd[MAXE_W-1:0]);
            fail_count++;
        end
    endtask

    task automatic drain_replies;
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [7:0] value);
        logic [APB_DW-1:0] rd;
        drain_replies();
        apb_access(1'b1, APB_DW'(value), rd);
        heap_limit = value;
        check_limit_readback(value);
    endtask

    task automatic run_phase(input int n, input int ins_pct);
        logic              op;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        int                roll;
        for (int k = 0; k < n; k++) begin
            op   = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
            code = CODE_W'($urandom);
            roll = $urandom_range(9);
            // narrow keys force ties; extremes now and then
            if (roll < 5)
                prio = PRIO_W'($urandom);
            else if (roll < 8)
                prio = PRIO_W'($urandom_range(7));
            else
                prio = $urandom_range(1) ? '1 : '0;
            push_item(op, code, prio, 1'b0, '0);
        end
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge i_clk) begin : reply_check
        t_reply got;
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tdata[1:0]);
            got.code   = m_axis_tdata[17:2];
            got.prio   = m_axis_tdata[33:18];
            got.fill   = m_axis_tdata[41:34];
            if (m_axis_tdata[47:42] !== '0) begin
                $error("zero fill: expected 0, got %0h", m_axis_tdata[47:42]);
                fail_count++;
            end
            if (replies_due.size() == 0) begin
                $error("unexpected result transfer: %0h", m_axis_tdata);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.code !== want.code) begin
                    $error("out_code: expected %0h, got %0h", want.code, got.code);
                    fail_count++;
                end
                if (got.prio !== want.prio) begin
                    $error("out_priority: expected %0h, got %0h", want.prio, got.prio);
                    fail_count++;
                end
                if (got.fill !== want.fill) begin
                    $error("fill_count: expected %0d, got %0d", want.fill, got.fill);
                    fail_count++;
                end
                case (want.status)
                    ST_FULL:  n_refused++;
                    ST_EMPTY: n_empty++;
                    default:  ;
                endcase
                if (int'(want.fill) > peak_fill)
                    peak_fill = int'(want.fill);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable) || !i_rst_n) begin
            quiet_cycles = 0;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == OP_INSERT)
                    n_inserts++;
                else
                    n_extracts++;
            end
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        heap_fill  = 0;
        heap_limit = 8'(MAXE_RESET);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        check_limit_readback(8'(MAXE_RESET));

        for (int i = 0; i < DIR_N; i++) begin
            if (dir_rows[i].kind == ROW_CFG)
                set_limit(dir_rows[i].cfg);
            else
                push_item(dir_rows[i].op, dir_rows[i].code, dir_rows[i].prio,
                          dir_rows[i].typed, dir_rows[i].reply);
        end

        // beyond the store: capacity clamps to the depth
        set_limit(8'd255);
        src_idle_pct = 0;  sink_stall_pct = 0;
        run_phase(220, 85);

        set_limit(8'(MAXE_RESET));
        src_idle_pct = 72; sink_stall_pct = 0;
        run_phase(220, 15);

        set_limit(8'($urandom_range(12, 1)));
        src_idle_pct = 0;  sink_stall_pct = 72;
        run_phase(200, 55);

        set_limit(8'($urandom_range(60, 20)));
        src_idle_pct = 9;  sink_stall_pct = 9;
        run_phase(180, 60);

        set_limit(8'd0);
        src_idle_pct = 0;  sink_stall_pct = 0;
        run_phase(30, 70);

        set_limit(8'd1);
        src_idle_pct = 9;  sink_stall_pct = 72;
        run_phase(40, 50);

        set_limit(8'(MAXE_RESET));
        src_idle_pct = 72; sink_stall_pct = 72;
        run_phase(210, 60);

        drain_replies();
        repeat (40) @(posedge i_clk);

        $display("run covered %0d inserts and %0d extracts, %0d refused as full,",
                 n_inserts, n_extracts, n_refused);
        $display("%0d extracts on empty, peak fill %0d, %0d mismatches",
                 n_empty, peak_fill, fail_count);
        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_cfg.sv
rtl/mhpq_ctrl.sv
rtl/max_heap_priority_queue.sv
tb/tb.sv
